[design/lpfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Laser profile feature detector package
// Word types, register widths, reset values and register indexes.
// ----------------------------------------------------------------------------
package lpfd_pkg;

   localparam int COORD_BITS    = 16;
   localparam int IDX_BITS      = 12;
   localparam int WIN_BITS      = 5;
   localparam int GAP_BITS      = 34;
   localparam int COS_BITS      = 16;
   localparam int SHARP_BITS    = 20;
   localparam int SHARP_SHIFT   = 10;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 34;

   localparam int DEF_MAX_HALF_WINDOW    = 16;
   localparam int DEF_MAX_PROFILE_POINTS = 4096;

   localparam logic [WIN_BITS-1:0]          WIN_RESET   = 5'd5;
   localparam logic [GAP_BITS-1:0]          GAP_RESET   = 34'd25;
   localparam logic signed [COS_BITS-1:0]   COS_RESET   = 16'sh7FFF;
   localparam logic [SHARP_BITS-1:0]        SHARP_RESET = 20'd57600;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_WINDOW_HALF = 2'd0,
      CSR_GAP_LIMIT   = 2'd1,
      CSR_CORNER_COS  = 2'd2,
      CSR_SHARP_LIMIT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_coord;
      logic signed [COORD_BITS-1:0] y_coord;
      logic signed [COORD_BITS-1:0] z_coord;
      logic                         profile_end;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] out_x;
      logic signed [COORD_BITS-1:0] out_y;
      logic signed [COORD_BITS-1:0] out_z;
      logic [IDX_BITS-1:0]          point_index;
      logic                         is_endpoint;
      logic                         gap_before;
      logic                         gap_after;
      logic                         is_corner;
      logic                         is_sharp;
      logic                         last_result;
   } rsp_word_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] b_x;
      logic signed [COORD_BITS-1:0] b_y;
      logic signed [COORD_BITS-1:0] c_x;
      logic signed [COORD_BITS-1:0] c_y;
      logic signed [COORD_BITS-1:0] f_x;
      logic signed [COORD_BITS-1:0] f_y;
      logic signed [COS_BITS-1:0]   cos_limit;
      logic [SHARP_BITS-1:0]        sharp_limit;
   } geom_req_type;

   typedef struct packed {
      logic corner;
      logic sharp;
   } geom_rsp_type;

endpackage
`default_nettype wire

[design/lpfd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lpfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[design/lpfd_geom.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Window geometry pipeline
// Seven stages: corner test on the k-back and k-forward vectors, sharp test
// on the chord between the window ends.
// ----------------------------------------------------------------------------
module lpfd_geom import lpfd_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   start,
   input  geom_req_type req,
   output logic        done,
   output geom_rsp_type rsp
);

   localparam int CB = COORD_BITS;
   localparam int DB = CB + 1;
   localparam int PB = 2 * DB;
   localparam int SQ = 2 * CB;
   localparam int HW = SQ + 1;
   localparam int NW = 2 * HW;
   localparam int LW = 2 * COS_BITS - 1;
   localparam int QS = 2 * (COS_BITS - 1);
   localparam int RW = NW + LW;
   localparam int SW = HW + SHARP_BITS;
   localparam int TW = SQ + SHARP_SHIFT;
   localparam int VS = 7;

   function automatic logic signed [DB-1:0] sdiff(input logic signed [CB-1:0] a,
                                                  input logic signed [CB-1:0] b);
      return DB'(a) - DB'(b);
   endfunction

   logic [VS-1:0] v_ff;

   // stage 1
   logic signed [DB-1:0] ax_ff, ay_ff, bx_ff, by_ff, dx_ff, dy_ff;
   logic signed [COS_BITS-1:0] lim1_ff, lim2_ff, lim3_ff, lim4_ff, lim5_ff, lim6_ff;
   logic [SHARP_BITS-1:0] sl1_ff, sl2_ff, sl3_ff;
   // stage 2
   logic signed [PB-1:0] pax_ff, pay_ff, pbx_ff, pby_ff, pxx_ff, pyy_ff, pdx_ff, pdy_ff;
   logic signed [2*COS_BITS-1:0] plim_ff;
   // stage 3
   logic [HW-1:0] na_ff, nb_ff, ds2_ff;
   logic signed [PB-1:0] dot_ff;
   logic [SQ-1:0] dy2_ff;
   logic [LW-1:0] l3_ff, l4_ff;
   // stage 4
   logic [NW-1:0] dd_ff, nn_ff, dd5_ff;
   logic [SW-1:0] sr_ff;
   logic [TW-1:0] dyl_ff;
   logic zero4_ff, neg4_ff, ds0_4_ff;
   // stage 5
   logic [HW+LW-1:0] ph_ff, pl_ff;
   logic zero5_ff, neg5_ff, sharp5_ff;
   // stage 6
   logic [RW-1:0] rhs_ff, lhs_ff;
   logic zero6_ff, neg6_ff, sharp6_ff;
   // stage 7
   geom_rsp_type rsp_ff;

   logic [PB-1:0] dabs_in;
   logic [HW-1:0] dmag_in;
   logic          lim_pos_in;
   logic          corner_in;

   assign dabs_in = dot_ff[PB-1] ? PB'(-dot_ff) : PB'(dot_ff);
   assign dmag_in = dabs_in[HW-1:0];
   assign lim_pos_in = !lim6_ff[COS_BITS-1] && (lim6_ff != '0);

   always_comb begin
      if (zero6_ff) begin
         corner_in = lim_pos_in;
      end else if (!lim6_ff[COS_BITS-1] && neg6_ff) begin
         corner_in = 1'b1;
      end else if (lim6_ff[COS_BITS-1] && !neg6_ff) begin
         corner_in = 1'b0;
      end else if (!lim6_ff[COS_BITS-1]) begin
         corner_in = lhs_ff < rhs_ff;
      end else begin
         corner_in = lhs_ff > rhs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[VS-2:0], start};
      end
   end

   always_ff @(posedge clock) begin
      ax_ff   <= sdiff(req.c_x, req.b_x);
      ay_ff   <= sdiff(req.c_y, req.b_y);
      bx_ff   <= sdiff(req.f_x, req.c_x);
      by_ff   <= sdiff(req.f_y, req.c_y);
      dx_ff   <= sdiff(req.f_x, req.b_x);
      dy_ff   <= sdiff(req.f_y, req.b_y);
      lim1_ff <= req.cos_limit;
      sl1_ff  <= req.sharp_limit;

      pax_ff  <= ax_ff * ax_ff;
      pay_ff  <= ay_ff * ay_ff;
      pbx_ff  <= bx_ff * bx_ff;
      pby_ff  <= by_ff * by_ff;
      pxx_ff  <= ax_ff * bx_ff;
      pyy_ff  <= ay_ff * by_ff;
      pdx_ff  <= dx_ff * dx_ff;
      pdy_ff  <= dy_ff * dy_ff;
      plim_ff <= lim1_ff * lim1_ff;
      lim2_ff <= lim1_ff;
      sl2_ff  <= sl1_ff;

      na_ff   <= HW'(pax_ff[SQ-1:0]) + HW'(pay_ff[SQ-1:0]);
      nb_ff   <= HW'(pbx_ff[SQ-1:0]) + HW'(pby_ff[SQ-1:0]);
      ds2_ff  <= HW'(pdx_ff[SQ-1:0]) + HW'(pdy_ff[SQ-1:0]);
      dot_ff  <= pxx_ff + pyy_ff;
      dy2_ff  <= pdy_ff[SQ-1:0];
      l3_ff   <= plim_ff[LW-1:0];
      lim3_ff <= lim2_ff;
      sl3_ff  <= sl2_ff;

      dd_ff    <= NW'(dmag_in) * NW'(dmag_in);
      nn_ff    <= NW'(na_ff) * NW'(nb_ff);
      sr_ff    <= SW'(sl3_ff) * SW'(ds2_ff);
      dyl_ff   <= {dy2_ff, {SHARP_SHIFT{1'b0}}};
      zero4_ff <= (na_ff == '0) || (nb_ff == '0);
      neg4_ff  <= dot_ff[PB-1];
      ds0_4_ff <= ds2_ff == '0;
      lim4_ff  <= lim3_ff;
      l4_ff    <= l3_ff;

      ph_ff     <= (HW+LW)'(nn_ff[NW-1:HW]) * (HW+LW)'(l4_ff);
      pl_ff     <= (HW+LW)'(nn_ff[HW-1:0]) * (HW+LW)'(l4_ff);
      dd5_ff    <= dd_ff;
      zero5_ff  <= zero4_ff;
      neg5_ff   <= neg4_ff;
      lim5_ff   <= lim4_ff;
      sharp5_ff <= !ds0_4_ff && (SW'(dyl_ff) > sr_ff);

      rhs_ff    <= (RW'(ph_ff) << HW) + RW'(pl_ff);
      lhs_ff    <= RW'(dd5_ff) << QS;
      zero6_ff  <= zero5_ff;
      neg6_ff   <= neg5_ff;
      lim6_ff   <= lim5_ff;
      sharp6_ff <= sharp5_ff;

      rsp_ff.corner <= corner_in;
      rsp_ff.sharp  <= sharp6_ff;
   end

   assign done = v_ff[VS-1];
   assign rsp  = rsp_ff;

endmodule
`default_nettype wire

[design/laser_profile_feature_detector.sv]
`timescale 1ns / 1ps
`default_nettype none
// Flow: an accepted word passes S_GSQ and S_GCMP, where it is written into the
// ring; the input stays closed until every result that the word releases is
// loaded into the output register. Each result takes four reads through the
// single read port of the ring memory and a pass through the seven-stage
// geometry pipeline, and can be held by a stalled output register.
// Reset: synchronous, active high; clears the profile, registers to defaults.
// ----------------------------------------------------------------------------
// Laser profile feature detector
// Keeps the last 2*MAX_HALF_WINDOW+1 profile points in a ring memory and classifies each
// point: endpoint, gap before and after, corner and sharp.
// ----------------------------------------------------------------------------
module laser_profile_feature_detector import lpfd_pkg::*; #(
   parameter int MAX_HALF_WINDOW    = DEF_MAX_HALF_WINDOW,
   parameter int MAX_PROFILE_POINTS = DEF_MAX_PROFILE_POINTS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  req_word_type                  req_word,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_word_type                  rsp_word,
   input  wire logic                     csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int CB         = COORD_BITS;
   localparam int DB         = CB + 1;
   localparam int SQ         = 2 * CB;
   localparam int RING_DEPTH = 2 * MAX_HALF_WINDOW + 1;
   localparam int AW         = $clog2(RING_DEPTH);
   localparam int KW         = $clog2(MAX_HALF_WINDOW + 1);
   localparam int CW         = $clog2(MAX_PROFILE_POINTS);
   localparam int XW         = ((CW > KW) ? CW : KW) + 2;
   localparam int WW         = 3 * CB + 1;
   localparam int GCW        = (SQ + 2 > GAP_BITS) ? SQ + 2 : GAP_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_GSQ, S_GCMP, S_RC, S_RB, S_RF, S_RN, S_RCAP, S_GEO, S_OUT
   } state_type;

   // Ring pointer arithmetic, modulo the ring depth.
   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (AW+1)'(RING_DEPTH)) begin
         s = s - (AW+1)'(RING_DEPTH);
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + (AW+1)'(RING_DEPTH) - {1'b0, b};
      if (s >= (AW+1)'(RING_DEPTH)) begin
         s = s - (AW+1)'(RING_DEPTH);
      end
      return s[AW-1:0];
   endfunction

   // Configuration registers
   logic [WIN_BITS-1:0]        win_half_ff;
   logic [GAP_BITS-1:0]        gap_lim_ff;
   logic signed [COS_BITS-1:0] cos_lim_ff;
   logic [SHARP_BITS-1:0]      sharp_lim_ff;

   // Sequencer state
   state_type             state_ff;
   logic [CW-1:0]         m_ff;
   logic [AW-1:0]         wr_ptr_ff;
   logic [KW-1:0]         k_ff;
   logic                  ended_ff;
   logic [CW-1:0]         i_ff;
   logic [AW-1:0]         ip_ff;
   logic [3*CB-1:0]       pt_ff;
   logic [3*CB-1:0]       prev_ff;
   logic signed [DB-1:0]  gd_x_ff, gd_y_ff, gd_z_ff;
   logic [SQ-1:0]         gq_x_ff, gq_y_ff, gq_z_ff;
   logic [WW-1:0]         c_word_ff;
   logic [CB-1:0]         b_x_ff, b_y_ff, f_x_ff, f_y_ff;
   logic                  gap_n_ff;
   logic                  corner_raw_ff, sharp_raw_ff;
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff;

   // Datapath nets
   logic                  accept;
   logic [KW-1:0]         k_in;
   logic [AW-1:0]         ka;
   logic [XW-1:0]         mx, kx, ix;
   logic                  ended_in;
   logic signed [2*DB-1:0] sq_x_in, sq_y_in, sq_z_in;
   logic [GCW-1:0]        gap_sum_in;
   logic                  gap_in;
   logic                  ring_we;
   logic [WW-1:0]         ring_wdata;
   logic [AW-1:0]         ring_raddr;
   logic [WW-1:0]         ring_rdata;
   logic                  emit_go;
   logic [CW-1:0]         i_first;
   logic [AW-1:0]         ip_first;
   logic [AW-1:0]         ptr_next;
   logic                  last_item;
   logic                  out_free;
   logic                  rsp_load;
   logic                  is_last;
   logic                  corner_ok, sharp_ok;
   rsp_word_type          rsp_in;
   geom_req_type          geom_req;
   geom_rsp_type          geom_rsp;
   logic                  geom_start, geom_done;

   assign req_ready = state_ff == S_IDLE;
   assign accept    = req_valid && req_ready;

   // Clamp k to 1..MAX_HALF_WINDOW; latched at the first point of a profile.
   always_comb begin
      if (win_half_ff == '0) begin
         k_in = KW'(1);
      end else if (int'(win_half_ff) > MAX_HALF_WINDOW) begin
         k_in = KW'(MAX_HALF_WINDOW);
      end else begin
         k_in = KW'(win_half_ff);
      end
   end

   assign ka = AW'(k_ff);
   assign mx = XW'(m_ff);
   assign kx = XW'(k_ff);
   assign ix = XW'(i_ff);

   // The point that fills the counter is forced to close the profile.
   assign ended_in = req_word.profile_end || (mx >= XW'(MAX_PROFILE_POINTS - 1));

   // Squared 3-D distance to the previous point
   assign sq_x_in    = gd_x_ff * gd_x_ff;
   assign sq_y_in    = gd_y_ff * gd_y_ff;
   assign sq_z_in    = gd_z_ff * gd_z_ff;
   assign gap_sum_in = GCW'(gq_x_ff) + GCW'(gq_y_ff) + GCW'(gq_z_ff);
   assign gap_in     = (m_ff != '0) && (gap_sum_in > GCW'(gap_lim_ff));

   assign ring_we    = state_ff == S_GCMP;
   assign ring_wdata = {gap_in, pt_ff};
   assign ptr_next   = ring_add(wr_ptr_ff, AW'(1));

   // First point to classify: k behind the newest, or the start of a short profile.
   assign emit_go  = mx >= kx;
   assign i_first  = emit_go ? CW'(mx - kx) : '0;
   assign ip_first = emit_go ? ring_sub(wr_ptr_ff, ka) : '0;

   // Read order: centre, k back, k forward, next (for its gap flag).
   always_comb begin
      case (state_ff)
         S_RC:    ring_raddr = ip_ff;
         S_RB:    ring_raddr = ring_sub(ip_ff, ka);
         S_RF:    ring_raddr = ring_add(ip_ff, ka);
         S_RN:    ring_raddr = ring_add(ip_ff, AW'(1));
         default: ring_raddr = ip_ff;
      endcase
   end

   lpfd_ram #(
      .WIDTH (WW),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (ring_wdata),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   assign geom_start         = state_ff == S_RCAP;
   assign geom_req.b_x       = b_x_ff;
   assign geom_req.b_y       = b_y_ff;
   assign geom_req.c_x       = c_word_ff[CB-1:0];
   assign geom_req.c_y       = c_word_ff[2*CB-1:CB];
   assign geom_req.f_x       = f_x_ff;
   assign geom_req.f_y       = f_y_ff;
   assign geom_req.cos_limit = cos_lim_ff;
   assign geom_req.sharp_limit = sharp_lim_ff;

   lpfd_geom u_geom (
      .clock (clock),
      .reset (reset),
      .start (geom_start),
      .req   (geom_req),
      .done  (geom_done),
      .rsp   (geom_rsp)
   );

   // Flag ranges: corner needs k+1 <= i and, once the profile has ended,
   // i+k+1 <= m; sharp needs the whole window inside the profile.
   assign is_last   = ended_ff && (i_ff == m_ff);
   assign last_item = !ended_ff || (i_ff == m_ff);
   assign corner_ok = (ix >= kx + XW'(1)) && (!ended_ff || (ix + kx + XW'(1) <= mx));
   assign sharp_ok  = (ix >= kx) && (ix + kx <= mx);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = (state_ff == S_OUT) && out_free;

   always_comb begin
      rsp_in.out_x       = c_word_ff[CB-1:0];
      rsp_in.out_y       = c_word_ff[2*CB-1:CB];
      rsp_in.out_z       = c_word_ff[3*CB-1:2*CB];
      rsp_in.point_index = IDX_BITS'(i_ff);
      rsp_in.is_endpoint = (i_ff == '0) || is_last;
      rsp_in.gap_before  = (i_ff != '0) && c_word_ff[3*CB];
      rsp_in.gap_after   = (i_ff != m_ff) && gap_n_ff;
      rsp_in.is_corner   = corner_ok && corner_raw_ff;
      rsp_in.is_sharp    = sharp_ok && sharp_raw_ff;
      rsp_in.last_result = is_last;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         win_half_ff  <= WIN_RESET;
         gap_lim_ff   <= GAP_RESET;
         cos_lim_ff   <= COS_RESET;
         sharp_lim_ff <= SHARP_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_WINDOW_HALF: win_half_ff  <= csr_wdata[WIN_BITS-1:0];
            CSR_GAP_LIMIT:   gap_lim_ff   <= csr_wdata[GAP_BITS-1:0];
            CSR_CORNER_COS:  cos_lim_ff   <= $signed(csr_wdata[COS_BITS-1:0]);
            CSR_SHARP_LIMIT: sharp_lim_ff <= csr_wdata[SHARP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer: take a word, write it into the ring, then classify every point
   // that it releases, one at a time.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         m_ff         <= '0;
         wr_ptr_ff    <= '0;
         k_ff         <= KW'(1);
         ended_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a new result word, or drop the old one once taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  pt_ff    <= {req_word.z_coord, req_word.y_coord, req_word.x_coord};
                  gd_x_ff  <= DB'(req_word.x_coord) - DB'($signed(prev_ff[CB-1:0]));
                  gd_y_ff  <= DB'(req_word.y_coord) - DB'($signed(prev_ff[2*CB-1:CB]));
                  gd_z_ff  <= DB'(req_word.z_coord) - DB'($signed(prev_ff[3*CB-1:2*CB]));
                  ended_ff <= ended_in;
                  if (m_ff == '0) begin
                     k_ff <= k_in;
                  end
                  state_ff <= S_GSQ;
               end
            end
            S_GSQ: begin
               gq_x_ff  <= sq_x_in[SQ-1:0];
               gq_y_ff  <= sq_y_in[SQ-1:0];
               gq_z_ff  <= sq_z_in[SQ-1:0];
               state_ff <= S_GCMP;
            end
            S_GCMP: begin
               // ring write happens in this cycle
               prev_ff <= pt_ff;
               if (!ended_ff && !emit_go) begin
                  m_ff      <= m_ff + CW'(1);
                  wr_ptr_ff <= ptr_next;
                  state_ff  <= S_IDLE;
               end else begin
                  i_ff     <= i_first;
                  ip_ff    <= ip_first;
                  state_ff <= S_RC;
               end
            end
            S_RC: begin
               state_ff <= S_RB;
            end
            S_RB: begin
               c_word_ff <= ring_rdata;
               state_ff  <= S_RF;
            end
            S_RF: begin
               b_x_ff   <= ring_rdata[CB-1:0];
               b_y_ff   <= ring_rdata[2*CB-1:CB];
               state_ff <= S_RN;
            end
            S_RN: begin
               f_x_ff   <= ring_rdata[CB-1:0];
               f_y_ff   <= ring_rdata[2*CB-1:CB];
               state_ff <= S_RCAP;
            end
            S_RCAP: begin
               gap_n_ff <= ring_rdata[3*CB];
               state_ff <= S_GEO;
            end
            S_GEO: begin
               if (geom_done) begin
                  corner_raw_ff <= geom_rsp.corner;
                  sharp_raw_ff  <= geom_rsp.sharp;
                  state_ff      <= S_OUT;
               end
            end
            S_OUT: begin
               // hold until the output register is free
               if (out_free) begin
                  rsp_word_ff  <= rsp_in;
                  if (last_item) begin
                     if (ended_ff) begin
                        m_ff      <= '0;
                        wr_ptr_ff <= '0;
                     end else begin
                        m_ff      <= m_ff + CW'(1);
                        wr_ptr_ff <= ptr_next;
                     end
                     state_ff <= S_IDLE;
                  end else begin
                     i_ff     <= i_ff + CW'(1);
                     ip_ff    <= ring_add(ip_ff, AW'(1));
                     state_ff <= S_RC;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire

[design/lpfd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker
// Watches the detector's channels over time.
// ----------------------------------------------------------------------------
module lpfd_assert import lpfd_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   input wire logic   req_valid,
   input wire logic   req_ready,
   input wire logic   rsp_valid,
   input wire logic   rsp_ready,
   input rsp_word_type rsp_word
);

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // Each accepted word closes the input in the cycle after its accept.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input reopened straight after accept");

   // Corner and sharp points lie strictly inside the profile.
   a_flags_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.is_corner || rsp_word.is_sharp) |-> !rsp_word.is_endpoint)
      else $error("corner or sharp flag on an endpoint");

   // The final result of a profile is an endpoint without a gap after it.
   a_last_endpoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.last_result |-> rsp_word.is_endpoint && !rsp_word.gap_after)
      else $error("last result not marked as endpoint");

endmodule

bind laser_profile_feature_detector lpfd_assert u_lpfd_assert (.*);
`default_nettype wire

[verif/lpfd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laser profile feature detector checker
// Snoops the register port and both channels, predicts the classified
// points of every accepted word and compares each result word in order.
// ----------------------------------------------------------------------------
module lpfd_checker import lpfd_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  req_word_type                  req_word,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  rsp_word_type                  rsp_word,
   input  wire logic                     csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int                            fail_count,
   output int                            pending
);

   localparam int HALF_MAX   = DEF_MAX_HALF_WINDOW;
   localparam int RING       = 2 * HALF_MAX + 1;
   localparam int POINTS_MAX = DEF_MAX_PROFILE_POINTS;

   logic [WIN_BITS-1:0]        win_reg;
   logic [GAP_BITS-1:0]        gap_reg;
   logic signed [COS_BITS-1:0] cos_reg;
   logic [SHARP_BITS-1:0]      sharp_reg;

   longint ring_x [RING];
   longint ring_y [RING];
   longint ring_z [RING];
   bit     gap_seen [RING];
   int     seen_count;
   int     k_held;

   rsp_word_type expected_points [$];

   function automatic bit corner_hit(int i, int k);
      longint ax, ay, bx, by, na, nb, dot, lim, mdot, mlim;
      logic [127:0] lhs, rhs;
      ax = ring_x[i % RING] - ring_x[(i - k) % RING];
      ay = ring_y[i % RING] - ring_y[(i - k) % RING];
      bx = ring_x[(i + k) % RING] - ring_x[i % RING];
      by = ring_y[(i + k) % RING] - ring_y[i % RING];
      na = ax * ax + ay * ay;
      nb = bx * bx + by * by;
      lim = longint'(cos_reg);
      dot = ax * bx + ay * by;
      if (na == 0 || nb == 0) return lim > 0;
      if (lim >= 0 && dot < 0) return 1'b1;
      if (lim < 0 && dot >= 0) return 1'b0;
      mdot = (dot < 0) ? -dot : dot;
      mlim = (lim < 0) ? -lim : lim;
      lhs = mdot;
      lhs = (lhs * lhs) << 30;
      rhs = na;
      rhs = rhs * nb;
      rhs = rhs * (mlim * mlim);
      return (lim >= 0) ? (lhs < rhs) : (lhs > rhs);
   endfunction

   function automatic bit sharp_hit(int i, int k);
      longint dx, dy;
      logic [127:0] lhs, rhs;
      dx = ring_x[(i + k) % RING] - ring_x[(i - k) % RING];
      dy = ring_y[(i + k) % RING] - ring_y[(i - k) % RING];
      if (dx * dx + dy * dy == 0) return 1'b0;
      lhs = dy * dy;
      lhs = lhs << SHARP_SHIFT;
      rhs = sharp_reg;
      rhs = rhs * (dx * dx + dy * dy);
      return lhs > rhs;
   endfunction

   function automatic rsp_word_type classify_point(int i, int m, bit ended);
      rsp_word_type w;
      int s;
      bit last;
      s = i % RING;
      last = ended && i == m;
      w.out_x       = ring_x[s][COORD_BITS-1:0];
      w.out_y       = ring_y[s][COORD_BITS-1:0];
      w.out_z       = ring_z[s][COORD_BITS-1:0];
      w.point_index = i[IDX_BITS-1:0];
      w.is_endpoint = (i == 0) || last;
      w.gap_before  = (i > 0) && gap_seen[s];
      w.gap_after   = (i < m) && gap_seen[(i + 1) % RING];
      w.is_corner   = (i >= k_held + 1) && (!ended || i + k_held + 1 <= m)
                      && corner_hit(i, k_held);
      w.is_sharp    = (i >= k_held) && (i + k_held <= m) && sharp_hit(i, k_held);
      w.last_result = last;
      return w;
   endfunction

   task automatic predict_word(req_word_type r);
      int m, s, p;
      bit ended;
      longint x, y, z, dx, dy, dz;
      m = seen_count;
      s = m % RING;
      ended = r.profile_end || m >= POINTS_MAX - 1;
      x = r.x_coord;
      y = r.y_coord;
      z = r.z_coord;
      if (m == 0) begin
         k_held = (win_reg < 1) ? 1 : (win_reg > HALF_MAX) ? HALF_MAX : int'(win_reg);
         gap_seen[s] = 1'b0;
      end else begin
         p = (m - 1) % RING;
         dx = x - ring_x[p];
         dy = y - ring_y[p];
         dz = z - ring_z[p];
         gap_seen[s] = (dx * dx + dy * dy + dz * dz) > longint'(gap_reg);
      end
      ring_x[s] = x;
      ring_y[s] = y;
      ring_z[s] = z;
      if (!ended) begin
         if (m >= k_held)
            expected_points.insert(expected_points.size(),
                                   classify_point(m - k_held, m, 1'b0));
         seen_count = m + 1;
      end else begin
         for (int i = (m >= k_held) ? m - k_held : 0; i <= m; i++)
            expected_points.insert(expected_points.size(), classify_point(i, m, 1'b1));
         seen_count = 0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         win_reg    = WIN_RESET;
         gap_reg    = GAP_RESET;
         cos_reg    = COS_RESET;
         sharp_reg  = SHARP_RESET;
         seen_count = 0;
         k_held     = 5;
         for (int j = 0; j < RING; j++) begin
            ring_x[j] = 0;
            ring_y[j] = 0;
            ring_z[j] = 0;
            gap_seen[j] = 1'b0;
         end
         expected_points.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result word %p", rsp_word);
            end else if (expected_points[0] !== rsp_word) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: expected %p actual %p", expected_points[0], rsp_word);
               void'(expected_points.pop_front());
            end else begin
               void'(expected_points.pop_front());
            end
         end
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_WINDOW_HALF: win_reg   = csr_wdata[WIN_BITS-1:0];
               CSR_GAP_LIMIT:   gap_reg   = csr_wdata[GAP_BITS-1:0];
               CSR_CORNER_COS:  cos_reg   = csr_wdata[COS_BITS-1:0];
               CSR_SHARP_LIMIT: sharp_reg = csr_wdata[SHARP_BITS-1:0];
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) predict_word(req_word);
      end
      pending = expected_points.size();
   end

endmodule

[verif/laser_profile_feature_detector_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laser profile feature detector testbench
// Streams directed and random profiles through the detector under several
// idling patterns and register settings; the checker judges every result.
// ----------------------------------------------------------------------------
module laser_profile_feature_detector_tb;
   import lpfd_pkg::*;

   // Idle cycles tolerated with no word moving on either channel.
   localparam int STALL_LIMIT = 20000;
   // Long receiver hold-off, enough to back the block up to its input.
   localparam int HOLD_CYCLES = 400;
   // Settle time after the last expected result.
   localparam int SETTLE      = 24;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int idle_pct  = 0;     // sender idle share, percent
   int stall_pct = 0;     // receiver stall share, percent
   bit hold_req  = 1'b0;  // raised by the stimulus, served by the receiver
   bit hold_done = 1'b0;
   int quiet_cycles = 0;

   always #1 clock = ~clock;

   laser_profile_feature_detector dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   lpfd_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offer one word; keep valid high into the next word unless a gap is drawn.
   task automatic send_word(int x, int y, int z, bit last);
      req_word_type w;
      w.x_coord     = x[COORD_BITS-1:0];
      w.y_coord     = y[COORD_BITS-1:0];
      w.z_coord     = z[COORD_BITS-1:0];
      w.profile_end = last;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   // Pause the sender until every expected word has come back, then settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] d);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Random profile: mostly a plausible scan line, sometimes pure noise.
   task automatic send_profile(int len, bit noisy);
      int x, y, z;
      x = -$urandom_range(2000);
      y = $urandom_range(400) - 200;
      z = $urandom_range(40) - 20;
      for (int j = 0; j < len; j++) begin
         if (noisy) begin
            x = $urandom;
            y = $urandom;
            z = $urandom;
         end else begin
            x += $urandom_range(40);
            y += ($urandom_range(99) < 10) ? $urandom_range(6000) - 3000
                                           : $urandom_range(60) - 30;
            z += $urandom_range(6) - 3;
         end
         send_word(x, y, z, j == len - 1);
      end
   endtask

   // Random register setting, small windows mostly, extremes now and then.
   task automatic random_setting();
      logic [CSR_DATA_BITS-1:0] d;
      d = ($urandom_range(99) < 15) ? $urandom_range(31) : $urandom_range(1, 6);
      write_reg(CSR_WINDOW_HALF, d);
      d = CSR_DATA_BITS'({$urandom, $urandom});
      write_reg(CSR_GAP_LIMIT, ($urandom_range(1)) ? d : $urandom_range(20000));
      write_reg(CSR_CORNER_COS, $urandom_range(65535));
      write_reg(CSR_SHARP_LIMIT, ($urandom_range(1)) ? $urandom_range(1048575)
                                                      : $urandom_range(100000));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single point profile at the coordinate extremes.
      send_word(-32768, 32767, -32768, 1'b1);
      drain();

      // Window zero acts as one; repeated points give zero vectors and chords.
      write_reg(CSR_WINDOW_HALF, 0);
      write_reg(CSR_GAP_LIMIT, 0);
      write_reg(CSR_CORNER_COS, 16'h7FFF);
      write_reg(CSR_SHARP_LIMIT, 0);
      send_word(0, 0, 0, 1'b0);
      send_word(0, 0, 0, 1'b0);
      send_word(0, 0, 0, 1'b0);
      send_word(5, 5, 5, 1'b1);
      drain();

      // Profile exactly 2k+1 long with opposite extremes, limits at their extremes.
      write_reg(CSR_WINDOW_HALF, 2);
      write_reg(CSR_GAP_LIMIT, {CSR_DATA_BITS{1'b1}});
      write_reg(CSR_CORNER_COS, 16'h8000);
      write_reg(CSR_SHARP_LIMIT, 20'hFFFFF);
      send_word(-32768, -32768, 32767, 1'b0);
      send_word(-100, 32767, -32768, 1'b0);
      send_word(0, 0, 0, 1'b0);
      send_word(100, -32768, 32767, 1'b0);
      send_word(32767, 32767, -32768, 1'b1);
      drain();

      // Window above the maximum clamps; a two point profile is short.
      write_reg(CSR_WINDOW_HALF, 31);
      write_reg(CSR_CORNER_COS, 0);
      send_word(-3, 7, 1, 1'b0);
      send_word(9, -7, 40, 1'b1);
      drain();

      // A right-angle shape, and a window change written mid-profile while
      // the block is quiet.
      write_reg(CSR_WINDOW_HALF, 1);
      write_reg(CSR_CORNER_COS, 23170);
      write_reg(CSR_SHARP_LIMIT, 57600);
      write_reg(CSR_GAP_LIMIT, 25);
      send_word(0, 0, 0, 1'b0);
      send_word(10, 0, 0, 1'b0);
      send_word(20, 0, 0, 1'b0);
      drain();
      write_reg(CSR_WINDOW_HALF, 3);
      send_word(20, 10, 0, 1'b0);
      send_word(20, 20, 0, 1'b0);
      send_word(22, 21, 1, 1'b1);
      drain();

      // Random phases: no idling, sender idle, receiver stalling, both.
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = (phase == 1) ? 53 : (phase == 3) ? 18 : 0;
         stall_pct = (phase == 2) ? 53 : (phase == 3) ? 18 : 0;
         random_setting();
         if (phase == 2) hold_req = 1'b1;   // back up the block during this phase
         for (int p = 0; p < 3; p++) begin
            send_profile($urandom_range(1, 18), $urandom_range(99) < 20);
            if ($urandom_range(1)) begin
               drain();
               random_setting();
            end
         end
         drain();
      end

      drain();
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[filelist.f]
design/lpfd_pkg.sv
design/lpfd_ram.sv
design/lpfd_geom.sv
design/laser_profile_feature_detector.sv
design/lpfd_checker.sv
verif/lpfd_checker.sv
verif/laser_profile_feature_detector_tb.sv
